### src/axis_calibrate_normalize_core_defines.svh
// Assertion macros shared by the axis calibration core.
`ifndef AXIS_CALIBRATE_NORMALIZE_CORE_DEFINES_SVH
`define AXIS_CALIBRATE_NORMALIZE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define ACN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same cycle check");

`define ACN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next cycle check");

`else

`define ACN_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ACN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/acn_pkg.sv
`default_nettype none
package acn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SPAN_W = SAMPLE_BITS + 1;
    localparam int QUO_W = SAMPLE_BITS;
    localparam int DIV_STEPS = SAMPLE_BITS;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample Q_POS_ONE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample Q_NEG_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample RESET_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample RESET_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample RESET_IDLE = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MIN = 3'd0,
        REG_RANGE_MAX = 3'd1,
        REG_IDLE_OFFSET = 3'd2,
        REG_NORMALIZE_EN = 3'd3,
        REG_CALIBRATE_EN = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CAPTURE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_status;

endpackage
`default_nettype wire

### src/acn_ctrl.sv
`default_nettype none
`include "axis_calibrate_normalize_core_defines.svh"
module acn_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire logic           i_ready,
    output acn_pkg::t_cmd       o_cmd,
    input  wire acn_pkg::t_status i_status
);
    import acn_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_cnt = '0;
                if (i_status.need_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `ACN_ASSERT_NEXT(a_accept_to_eval, i_clk, i_rst_n, i_valid && o_ready, r_state == S_EVAL)
    `ACN_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_ready)
    `ACN_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && r_cnt == CNT_LAST,
        r_state == S_DONE)
    `ACN_ASSERT_NEXT(a_direct_path, i_clk, i_rst_n, o_cmd.eval && !i_status.need_div,
        r_state == S_DONE)

endmodule
`default_nettype wire

### src/acn_datapath.sv
`default_nettype none
`include "axis_calibrate_normalize_core_defines.svh"
module acn_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [acn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [acn_pkg::SAMPLE_BITS-1:0] i_cfg_data,
    input  wire logic                          i_op,
    input  wire acn_pkg::t_sample              i_raw_sample,
    input  wire acn_pkg::t_cmd                 i_cmd,
    output acn_pkg::t_status                   o_status,
    output acn_pkg::t_sample                   o_axis_value,
    output logic                               o_is_normalized,
    output logic                               o_saturated
);
    import acn_pkg::*;

    t_sample r_range_min, r_range_max;
    logic r_norm_en, r_cal_en;
    t_sample r_low, r_high, r_idle, r_last;
    t_sample n_low, n_high, n_idle, n_last;
    t_sample w_cfg_min, w_cfg_max, w_cfg_sample;

    logic signed [SPAN_W-1:0] w_last_x, w_idle_x, w_low_x, w_high_x, w_d;
    logic [SPAN_W-1:0] w_mag, w_span;
    logic w_neg, w_active, w_zero, w_over;

    logic r_neg, r_active, r_zero, r_over;
    logic [SPAN_W-1:0] r_span, r_rem, w_diff, w_rem_sel;
    logic [QUO_W-1:0] r_quo, w_quo_neg;
    logic w_ge;

    t_sample r_out_value;
    logic r_out_norm, r_out_sat;

    assign w_cfg_sample = t_sample'(i_cfg_data);
    assign w_cfg_min = (i_cfg_index == REG_RANGE_MIN) ? w_cfg_sample : r_range_min;
    assign w_cfg_max = (i_cfg_index == REG_RANGE_MAX) ? w_cfg_sample : r_range_max;

    always_comb begin
        n_low = r_low;
        n_high = r_high;
        n_idle = r_idle;
        n_last = r_last;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RANGE_MIN, REG_RANGE_MAX: begin
                    if (w_cfg_min < w_cfg_max) begin
                        n_low = w_cfg_min;
                        n_high = w_cfg_max;
                    end
                end
                REG_IDLE_OFFSET: begin
                    n_idle = w_cfg_sample;
                    if (r_cal_en) begin
                        n_low = w_cfg_sample;
                        n_high = w_cfg_sample;
                    end
                end
                REG_CALIBRATE_EN: begin
                    if (i_cfg_data[0]) begin
                        n_low = r_idle;
                        n_high = r_idle;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.load) begin
            if (i_op == OP_SAMPLE) begin
                n_last = i_raw_sample;
                if (r_cal_en) begin
                    if (i_raw_sample < r_low) begin
                        n_low = i_raw_sample;
                    end
                    if (i_raw_sample > r_high) begin
                        n_high = i_raw_sample;
                    end
                end
            end else begin
                n_idle = r_last;
                if (r_cal_en) begin
                    n_low = r_last;
                    n_high = r_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= RESET_MIN;
            r_range_max <= RESET_MAX;
            r_norm_en <= 1'b0;
            r_cal_en <= 1'b0;
            r_low <= RESET_MIN;
            r_high <= RESET_MAX;
            r_idle <= RESET_IDLE;
            r_last <= '0;
        end else begin
            r_low <= n_low;
            r_high <= n_high;
            r_idle <= n_idle;
            r_last <= n_last;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RANGE_MIN: r_range_min <= w_cfg_sample;
                    REG_RANGE_MAX: r_range_max <= w_cfg_sample;
                    REG_NORMALIZE_EN: r_norm_en <= i_cfg_data[0];
                    REG_CALIBRATE_EN: r_cal_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_last_x = {r_last[SAMPLE_BITS-1], r_last};
    assign w_idle_x = {r_idle[SAMPLE_BITS-1], r_idle};
    assign w_low_x = {r_low[SAMPLE_BITS-1], r_low};
    assign w_high_x = {r_high[SAMPLE_BITS-1], r_high};
    assign w_d = w_last_x - w_idle_x;
    assign w_neg = w_d[SPAN_W-1];
    assign w_mag = w_neg ? SPAN_W'(-w_d) : SPAN_W'(w_d);
    assign w_span = w_neg ? SPAN_W'(w_idle_x - w_low_x) : SPAN_W'(w_high_x - w_idle_x);
    assign w_active = r_norm_en && (r_low < r_high) && (r_low <= r_idle) && (r_idle <= r_high);
    assign w_zero = (w_span == '0);
    assign w_over = (w_mag > w_span);
    assign o_status.need_div = w_active && !w_zero && !w_over;

    assign w_ge = (r_rem >= r_span);
    assign w_diff = r_rem - r_span;
    assign w_rem_sel = w_ge ? w_diff : r_rem;
    assign w_quo_neg = ~r_quo + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_neg <= w_neg;
            r_active <= w_active;
            r_zero <= w_zero;
            r_over <= w_over;
            r_span <= w_span;
            r_rem <= w_mag;
            r_quo <= '0;
        end else if (i_cmd.step) begin
            r_rem <= {w_rem_sel[SPAN_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_norm <= r_active;
            r_out_sat <= r_active && !r_zero && r_over;
            if (!r_active) begin
                r_out_value <= r_last;
            end else if (r_zero) begin
                r_out_value <= '0;
            end else if (r_over) begin
                r_out_value <= r_neg ? Q_NEG_ONE : Q_POS_ONE;
            end else if (r_neg) begin
                r_out_value <= t_sample'(w_quo_neg);
            end else if (r_quo[QUO_W-1]) begin
                r_out_value <= Q_POS_ONE;
            end else begin
                r_out_value <= t_sample'(r_quo);
            end
        end
    end

    assign o_axis_value = r_out_value;
    assign o_is_normalized = r_out_norm;
    assign o_saturated = r_out_sat;

    `ACN_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n, i_cmd.step,
        {1'b0, r_rem} < {r_span, 1'b0})
    `ACN_ASSERT_NEXT(a_div_span_nonzero, i_clk, i_rst_n, i_cmd.eval && o_status.need_div,
        r_span != '0)
    `ACN_ASSERT_NEXT(a_sat_only_normalized, i_clk, i_rst_n, i_cmd.out_load,
        !r_out_sat || r_out_norm)

endmodule
`default_nettype wire

### src/axis_calibrate_normalize_core.sv
// Axis calibration and normalization core. Each input word is either a raw
// signed sample or a command to capture the last sample as the idle point, and
// each one yields exactly one output word. With calibration enabled the low and
// high extents widen to cover every sample, and a capture collapses them onto
// the new idle point. When normalization is enabled and the extents are valid,
// the output is the offset from the idle point divided by the span on that side
// as Q1.15, clamped to plus or minus one; otherwise the raw sample passes
// through. Words that need a division go through the restoring divider, which
// resolves one quotient bit per cycle. One word is processed at a time, and a
// new word is accepted while the previous result still waits in the output
// register. Configuration writes are always ready and must only be issued
// while no word is in flight.
`default_nettype none
module axis_calibrate_normalize_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire acn_pkg::t_sample              i_raw_sample,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output acn_pkg::t_sample                   o_axis_value,
    output logic                               o_is_normalized,
    output logic                               o_saturated,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [acn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [acn_pkg::SAMPLE_BITS-1:0] i_cfg_data
);
    import acn_pkg::*;

    t_cmd w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    acn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    acn_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_raw_sample    (i_raw_sample),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_axis_value    (o_axis_value),
        .o_is_normalized (o_is_normalized),
        .o_saturated     (o_saturated)
    );

endmodule
`default_nettype wire

### test/axis_calibrate_normalize_core_tb.sv
`timescale 1ns / 100ps

module axis_calibrate_normalize_core_tb;
    import acn_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_HOLD = 4;
    localparam int END_HOLD = 40;
    localparam int RANDOM_CHUNKS = 10;
    localparam int CHUNK_WORDS = 65;
    localparam int CAPTURE_PCT = 8;

    typedef logic [SAMPLE_BITS-1:0] t_cfg_data;

    typedef struct packed {
        t_sample axis_value;
        logic    is_normalized;
        logic    saturated;
    } t_axis_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_op = OP_SAMPLE;
    t_sample              i_raw_sample = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_sample              o_axis_value;
    logic                 o_is_normalized;
    logic                 o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    t_cfg_data            i_cfg_data = '0;

    // Shadow copy of the configuration and tracking state.
    t_sample cfg_range_min;
    t_sample cfg_range_max;
    t_sample cfg_idle_offset;
    logic    cfg_normalize_en;
    logic    cfg_calibrate_en;
    t_sample low_ext;
    t_sample high_ext;
    t_sample idle_pt;
    t_sample last_smp;
    logic    norm_active;

    t_axis_word pending_words[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         error_count = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    int         regs_written = 0;

    axis_calibrate_normalize_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_raw_sample    (i_raw_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_axis_value    (o_axis_value),
        .o_is_normalized (o_is_normalized),
        .o_saturated     (o_saturated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void reset_shadow();
        cfg_range_min = RESET_MIN;
        cfg_range_max = RESET_MAX;
        cfg_idle_offset = RESET_IDLE;
        cfg_normalize_en = 1'b0;
        cfg_calibrate_en = 1'b0;
        low_ext = RESET_MIN;
        high_ext = RESET_MAX;
        idle_pt = RESET_IDLE;
        last_smp = '0;
        norm_active = 1'b0;
    endfunction

    function automatic void refresh_active();
        norm_active = cfg_normalize_en && (low_ext < high_ext) &&
                      (low_ext <= idle_pt) && (idle_pt <= high_ext);
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, t_cfg_data data);
        case (idx)
            REG_RANGE_MIN, REG_RANGE_MAX: begin
                if (idx == REG_RANGE_MIN) begin
                    cfg_range_min = t_sample'(data);
                end else begin
                    cfg_range_max = t_sample'(data);
                end
                if (cfg_range_min < cfg_range_max) begin
                    low_ext = cfg_range_min;
                    high_ext = cfg_range_max;
                end
            end
            REG_IDLE_OFFSET: begin
                cfg_idle_offset = t_sample'(data);
                idle_pt = cfg_idle_offset;
                if (cfg_calibrate_en) begin
                    low_ext = idle_pt;
                    high_ext = idle_pt;
                end
            end
            REG_NORMALIZE_EN: begin
                cfg_normalize_en = data[0];
            end
            REG_CALIBRATE_EN: begin
                cfg_calibrate_en = data[0];
                if (cfg_calibrate_en) begin
                    low_ext = idle_pt;
                    high_ext = idle_pt;
                end
            end
            default: begin
                return;
            end
        endcase
        refresh_active();
    endfunction

    function automatic t_axis_word predict_axis_word(t_op op, t_sample smp);
        t_axis_word res;
        longint     offset;
        longint     span;
        longint     mag;
        longint     value;

        res.saturated = 1'b0;
        if (op == OP_SAMPLE) begin
            if (cfg_calibrate_en) begin
                if (smp < low_ext) low_ext = smp;
                if (smp > high_ext) high_ext = smp;
            end
            last_smp = smp;
        end else begin
            idle_pt = last_smp;
            if (cfg_calibrate_en) begin
                low_ext = idle_pt;
                high_ext = idle_pt;
            end
        end
        refresh_active();

        if (norm_active) begin
            offset = longint'(last_smp) - longint'(idle_pt);
            span = (offset < 0) ? longint'(idle_pt) - longint'(low_ext)
                                : longint'(high_ext) - longint'(idle_pt);
            mag = (offset < 0) ? -offset : offset;
            if (span == 0) begin
                value = 0;
            end else if (mag > span) begin
                value = (offset < 0) ? -32768 : 32767;
                res.saturated = 1'b1;
            end else begin
                value = (offset * 32768) / span;
                if (value > 32767) value = 32767;
            end
        end else begin
            value = longint'(last_smp);
        end
        res.axis_value = t_sample'(value);
        res.is_normalized = norm_active;
        return res;
    endfunction

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_axis_word want;
        if (i_rst_n && o_valid && i_ready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word value=%0d norm=%0b sat=%0b", $time,
                         o_axis_value, o_is_normalized, o_saturated);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_axis_value !== want.axis_value) begin
                    $display("%0t: axis_value expected %0d actual %0d", $time,
                             want.axis_value, o_axis_value);
                    error_count++;
                end
                if (o_is_normalized !== want.is_normalized) begin
                    $display("%0t: is_normalized expected %0b actual %0b", $time,
                             want.is_normalized, o_is_normalized);
                    error_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.saturated, o_saturated);
                    error_count++;
                end
            end
        end
    end

    task automatic send_word(t_op op, t_sample smp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_raw_sample <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_words.push_back(predict_axis_word(op, smp));
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_cfg_data data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg_write(idx, data);
        regs_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        return t_sample'($urandom_range(65535));
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            4, 5: return t_sample'(int'(idle_pt) + int'($urandom_range(128)) - 64);
            6: return t_sample'(int'(low_ext) + int'($urandom_range(16)) - 8);
            7: return t_sample'(int'(high_ext) + int'($urandom_range(16)) - 8);
            8: begin
                case ($urandom_range(3))
                    0: return RESET_MIN;
                    1: return RESET_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return random_sample();
        endcase
    endfunction

    task automatic test_passthrough_after_reset();
        send_word(OP_SAMPLE, RESET_MIN);
        send_word(OP_SAMPLE, RESET_MAX);
        send_word(OP_SAMPLE, '0);
        send_word(OP_CAPTURE, t_sample'(16'h5a5a));
        wait_drained();
    endtask

    task automatic test_register_writes();
        write_reg(REG_NORMALIZE_EN, t_cfg_data'(1));
        send_word(OP_SAMPLE, RESET_MAX);
        send_word(OP_SAMPLE, RESET_MIN);
        wait_drained();
        write_reg(REG_RANGE_MIN, t_cfg_data'(100));
        send_word(OP_SAMPLE, t_sample'(5));
        wait_drained();
        // An empty range leaves the extents where they were.
        write_reg(REG_RANGE_MAX, t_cfg_data'(-100));
        for (int k = int'(REG_CALIBRATE_EN) + 1; k < 2 ** CFG_IDX_W; k++) begin
            write_reg(k[CFG_IDX_W-1:0], t_cfg_data'(16'hffff));
        end
        send_word(OP_SAMPLE, t_sample'(-5));
        wait_drained();
        write_reg(REG_RANGE_MIN, t_cfg_data'(-100));
        write_reg(REG_RANGE_MAX, t_cfg_data'(100));
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(0));
    endtask

    task automatic test_normalize_edges();
        send_word(OP_SAMPLE, t_sample'(100));
        send_word(OP_SAMPLE, t_sample'(-100));
        send_word(OP_SAMPLE, t_sample'(-33));
        send_word(OP_SAMPLE, t_sample'(150));
        send_word(OP_SAMPLE, t_sample'(-150));
        send_word(OP_SAMPLE, t_sample'(0));
        wait_drained();
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(-100));
        send_word(OP_SAMPLE, t_sample'(-150));
        wait_drained();
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(200));
        send_word(OP_SAMPLE, t_sample'(7));
        wait_drained();
    endtask

    task automatic test_calibration();
        write_reg(REG_CALIBRATE_EN, t_cfg_data'(1));
        send_word(OP_SAMPLE, t_sample'(150));
        send_word(OP_SAMPLE, t_sample'(260));
        send_word(OP_CAPTURE, t_sample'(-1));
        wait_drained();
        write_reg(REG_CALIBRATE_EN, t_cfg_data'(0));
        write_reg(REG_RANGE_MIN, t_cfg_data'(RESET_MIN));
        write_reg(REG_RANGE_MAX, t_cfg_data'(RESET_MAX));
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(RESET_MIN));
        send_word(OP_SAMPLE, RESET_MAX);
        wait_drained();
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(RESET_MAX));
        send_word(OP_SAMPLE, RESET_MIN);
        wait_drained();
    endtask

    task automatic randomize_settings();
        int        lo;
        int        hi;
        int        mid;
        int        idle;
        logic      cal_first;
        t_cfg_data cal_data;

        case ($urandom_range(3))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = int'(random_sample());
                hi = int'(random_sample());
                if (lo > hi) begin
                    mid = lo;
                    lo = hi;
                    hi = mid;
                end
            end
            2: begin
                lo = int'(random_sample());
                hi = int'(random_sample());
            end
            default: begin
                mid = int'($urandom_range(60000)) - 30000;
                lo = mid - int'($urandom_range(200));
                hi = mid + int'($urandom_range(200));
            end
        endcase
        if ($urandom_range(3) != 0 && lo < hi) begin
            idle = lo + int'($urandom_range(hi - lo));
        end else begin
            idle = int'(random_sample());
        end
        cal_data = t_cfg_data'($urandom_range(65535));
        cal_data[0] = ($urandom_range(99) < 30);
        cal_first = ($urandom_range(1) == 1);

        if (cal_first) write_reg(REG_CALIBRATE_EN, cal_data);
        if ($urandom_range(1)) begin
            write_reg(REG_RANGE_MIN, t_cfg_data'(lo));
            write_reg(REG_RANGE_MAX, t_cfg_data'(hi));
        end else begin
            write_reg(REG_RANGE_MAX, t_cfg_data'(hi));
            write_reg(REG_RANGE_MIN, t_cfg_data'(lo));
        end
        write_reg(REG_IDLE_OFFSET, t_cfg_data'(idle));
        if (!cal_first) write_reg(REG_CALIBRATE_EN, cal_data);
        write_reg(REG_NORMALIZE_EN, {(SAMPLE_BITS-1)'($urandom_range(32767)),
                                     logic'($urandom_range(99) < 80)});
        if ($urandom_range(9) == 0) begin
            write_reg(CFG_IDX_W'(int'(REG_CALIBRATE_EN) + 1 + int'($urandom_range(2))),
                      t_cfg_data'($urandom_range(65535)));
        end
    endtask

    task automatic test_random_traffic(int chunks, int words);
        for (int c = 0; c < chunks; c++) begin
            wait_drained();
            randomize_settings();
            for (int n = 0; n < words; n++) begin
                if ($urandom_range(99) < CAPTURE_PCT) begin
                    send_word(OP_CAPTURE, random_sample());
                end else begin
                    send_word(OP_SAMPLE, pick_sample());
                end
            end
        end
    endtask

    initial begin
        reset_shadow();
        send_idle_pct = 37;
        recv_idle_pct = 57;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough_after_reset();
        test_register_writes();
        test_normalize_edges();
        test_calibration();
        test_random_traffic(RANDOM_CHUNKS, CHUNK_WORDS);

        send_idle_pct = 57;
        recv_idle_pct = 37;
        test_random_traffic(RANDOM_CHUNKS, CHUNK_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_CHUNKS, CHUNK_WORDS);

        wait_drained();
        repeat (END_HOLD) @(posedge i_clk);

        $display("Checked %0d of %0d axis words after %0d register writes,",
                 words_checked, words_sent, regs_written);
        $display("with both stall patterns, no-stall traffic and drains between settings.");
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
